// ===== rtl/core/pid_speed_loop_with_integral_separation_top_assert.svh =====
// Assertion macros for the PID speed loop, empty when SYNTHESIS is defined.
`ifndef PID_SPEED_LOOP_WITH_INTEGRAL_SEPARATION_TOP_ASSERT_SVH
`define PID_SPEED_LOOP_WITH_INTEGRAL_SEPARATION_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// Condition must hold at every clock edge out of reset
`define PIDSL_ASSERT(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("pid speed loop: invariant violated");

// When pre holds, post must hold in the next cycle
`define PIDSL_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("pid speed loop: sequence violated");

`else

`define PIDSL_ASSERT(label, cond)
`define PIDSL_ASSERT_NEXT(label, pre, post)

`endif

`endif

// ===== rtl/core/pidsl_pkg.sv =====
// Shared types, register codes and constants of the PID speed loop.
package pidsl_pkg;

  // Configuration register indexes
  localparam logic [2:0] REG_GAIN_P         = 3'd0;
  localparam logic [2:0] REG_GAIN_I         = 3'd1;
  localparam logic [2:0] REG_GAIN_D         = 3'd2;
  localparam logic [2:0] REG_SEPARATION     = 3'd3;
  localparam logic [2:0] REG_INTEGRAL_LIMIT = 3'd4;
  localparam logic [2:0] REG_OUTPUT_LIMIT   = 3'd5;
  localparam logic [2:0] REG_USE_DERIVATIVE = 3'd6;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // Reset values of the registers
  localparam logic [15:0] RST_SEPARATION     = 16'd65535;
  localparam logic [23:0] RST_INTEGRAL_LIMIT = 24'd10000;
  localparam logic [14:0] RST_OUTPUT_LIMIT   = 15'd9500;

  // Items allowed in flight: pipeline plus output queue
  localparam int CREDITS = 8;
  localparam int CNT_W   = $clog2(CREDITS + 1);
  localparam int PTR_W   = $clog2(CREDITS);

  typedef struct packed {
    logic [15:0] gain_p;
    logic [15:0] gain_i;
    logic [15:0] gain_d;
    logic [15:0] separation_threshold;
    logic [23:0] integral_limit;
    logic [14:0] output_limit;
    logic        use_derivative;
  } pidsl_cfg_t;

  typedef struct packed {
    logic              valid;
    logic signed [15:0] drive;
  } pidsl_res_t;

endpackage

// ===== rtl/core/pidsl_core.sv =====
// Three-stage PID datapath: error, integral/derivative state, products, saturation.
module pidsl_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_fire,
  input  logic signed [15:0]  tgt_speed,
  input  logic signed [15:0]  measured_speed,
  input  pidsl_pkg::pidsl_cfg_t cfg,
  output pidsl_pkg::pidsl_res_t res
);

  // Stage 1: error
  logic               s1_valid_r;
  logic signed [16:0] s1_err_r;

  // Stage 2: loop state and per-item terms
  logic               s2_valid_r;
  logic signed [16:0] s2_err_r;
  logic signed [24:0] s2_isum_r;
  logic signed [17:0] s2_diff_r;
  logic signed [24:0] isum_r, isum_nxt;
  logic signed [16:0] prev_err_r;

  // Stage 3: products
  logic               s3_valid_r;
  logic signed [33:0] p_prod_r;
  logic signed [41:0] i_prod_r;
  logic signed [34:0] d_prod_r;

  logic [16:0]        err_mag;
  logic               in_band;
  logic signed [25:0] isum_sum;
  logic signed [25:0] ilim;
  logic signed [17:0] diff;
  logic signed [33:0] p_prod;
  logic signed [41:0] i_prod;
  logic signed [34:0] d_prod;
  logic signed [35:0] total;
  logic signed [35:0] olim;
  logic signed [15:0] drive;

  // Integral with separation band, then clamp; derivative difference
  always_comb begin
    err_mag  = s1_err_r[16] ? 17'(-s1_err_r) : 17'(s1_err_r);
    in_band  = err_mag <= {1'b0, cfg.separation_threshold};
    ilim     = $signed({2'b00, cfg.integral_limit});
    isum_sum = 26'(isum_r) + (in_band ? 26'(s1_err_r) : 26'sd0);
    if (isum_sum > ilim) begin
      isum_nxt = 25'(ilim);
    end else if (isum_sum < -ilim) begin
      isum_nxt = 25'(-ilim);
    end else begin
      isum_nxt = 25'(isum_sum);
    end
    diff = cfg.use_derivative ? (18'(s1_err_r) - 18'(prev_err_r)) : 18'sd0;
  end

  // Gain products, each operand taken as signed with an unsigned gain
  always_comb begin
    p_prod = $signed({1'b0, cfg.gain_p}) * s2_err_r;
    i_prod = $signed({1'b0, cfg.gain_i}) * s2_isum_r;
    d_prod = $signed({1'b0, cfg.gain_d}) * s2_diff_r;
  end

  // Floor shift by 8, sum, saturate
  always_comb begin
    total = 36'($signed(p_prod_r[33:8])) + 36'($signed(i_prod_r[41:8]))
          + 36'($signed(d_prod_r[34:8]));
    olim  = $signed({21'd0, cfg.output_limit});
    if (total > olim) begin
      drive = 16'(olim);
    end else if (total < -olim) begin
      drive = 16'(-olim);
    end else begin
      drive = 16'(total);
    end
  end

  // Control and loop state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
      isum_r     <= '0;
      prev_err_r <= '0;
    end else begin
      s1_valid_r <= in_fire;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
      if (s1_valid_r) begin
        isum_r <= isum_nxt;
        if (cfg.use_derivative) begin
          prev_err_r <= s1_err_r;
        end
      end
    end
  end

  // Payload pipeline
  always_ff @(posedge clk) begin
    s1_err_r  <= 17'(tgt_speed) - 17'(measured_speed);
    s2_err_r  <= s1_err_r;
    s2_isum_r <= isum_nxt;
    s2_diff_r <= diff;
    p_prod_r  <= p_prod;
    i_prod_r  <= i_prod;
    d_prod_r  <= d_prod;
  end

  assign res.valid = s3_valid_r;
  assign res.drive = drive;

endmodule

// ===== rtl/core/pid_speed_loop_with_integral_separation_top.sv =====
// Top level of the PID speed loop: config registers, credit count, output queue.
//
// Usage:
// - Input channel (in_valid/in_ready) carries a target and a measured speed.
// - Result channel (out_valid/out_ready) carries one saturated drive per item.
// - Config port: cfg_we writes cfg_wdata into register cfg_index at the clock
//   edge (0 gain_p, 1 gain_i, 2 gain_d, 3 separation_threshold,
//   4 integral_limit, 5 output_limit, 6 use_derivative); index 7 is ignored.
//   Write only while no item is in flight.
// - Path: the drive passes the error, loop state and gain product registers
//   and then the queue before it is offered (sum and saturation feed the
//   queue directly).
// - Throughput: one item per cycle while in_ready is high; the integral update is a single add and
//   clamp on registered state, so each item sees the previous item's state.
// - Up to 8 items may be in flight; results wait in an 8-entry queue while the
//   receiver stalls, and in_ready drops once 8 results are owed.
// - Reset (rst_n low, synchronous) clears the integral, the last error, the
//   queue and restores register defaults.
module pid_speed_loop_with_integral_separation_top (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [15:0]                   in_target_speed,
  input  logic signed [15:0]                   in_measured_speed,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [15:0]                   out_drive,
  input  logic                                 cfg_we,
  input  logic [pidsl_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pidsl_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

`include "pid_speed_loop_with_integral_separation_top_assert.svh"

  pidsl_pkg::pidsl_cfg_t cfg_r;
  pidsl_pkg::pidsl_res_t res;

  logic [pidsl_pkg::CNT_W-1:0] inflight_r;
  logic [pidsl_pkg::CNT_W-1:0] fifo_cnt_r;
  logic [pidsl_pkg::PTR_W-1:0] wr_ptr_r;
  logic [pidsl_pkg::PTR_W-1:0] rd_ptr_r;
  logic signed [15:0]          fifo_mem_r [pidsl_pkg::CREDITS];

  logic in_fire;
  logic out_fire;

  assign in_ready  = inflight_r < pidsl_pkg::CNT_W'(pidsl_pkg::CREDITS);
  assign in_fire   = in_valid & in_ready;
  assign out_valid = fifo_cnt_r != '0;
  assign out_fire  = out_valid & out_ready;
  assign out_drive = fifo_mem_r[rd_ptr_r];

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain_p               <= '0;
      cfg_r.gain_i               <= '0;
      cfg_r.gain_d               <= '0;
      cfg_r.separation_threshold <= pidsl_pkg::RST_SEPARATION;
      cfg_r.integral_limit       <= pidsl_pkg::RST_INTEGRAL_LIMIT;
      cfg_r.output_limit         <= pidsl_pkg::RST_OUTPUT_LIMIT;
      cfg_r.use_derivative       <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        pidsl_pkg::REG_GAIN_P:         cfg_r.gain_p <= cfg_wdata[15:0];
        pidsl_pkg::REG_GAIN_I:         cfg_r.gain_i <= cfg_wdata[15:0];
        pidsl_pkg::REG_GAIN_D:         cfg_r.gain_d <= cfg_wdata[15:0];
        pidsl_pkg::REG_SEPARATION:     cfg_r.separation_threshold <= cfg_wdata[15:0];
        pidsl_pkg::REG_INTEGRAL_LIMIT: cfg_r.integral_limit <= cfg_wdata[23:0];
        pidsl_pkg::REG_OUTPUT_LIMIT:   cfg_r.output_limit <= cfg_wdata[14:0];
        pidsl_pkg::REG_USE_DERIVATIVE: cfg_r.use_derivative <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  pidsl_core u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_fire        (in_fire),
    .tgt_speed      (in_target_speed),
    .measured_speed (in_measured_speed),
    .cfg            (cfg_r),
    .res            (res)
  );

  // Credit count and queue pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inflight_r <= '0;
      fifo_cnt_r <= '0;
      wr_ptr_r   <= '0;
      rd_ptr_r   <= '0;
    end else begin
      case ({in_fire, out_fire})
        2'b10:   inflight_r <= inflight_r + 1'b1;
        2'b01:   inflight_r <= inflight_r - 1'b1;
        default: ;
      endcase
      case ({res.valid, out_fire})
        2'b10:   fifo_cnt_r <= fifo_cnt_r + 1'b1;
        2'b01:   fifo_cnt_r <= fifo_cnt_r - 1'b1;
        default: ;
      endcase
      if (res.valid) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (out_fire) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  // Queue storage
  always_ff @(posedge clk) begin
    if (res.valid) begin
      fifo_mem_r[wr_ptr_r] <= res.drive;
    end
  end

  // Checks
  `PIDSL_ASSERT(a_credit_bound, inflight_r <= pidsl_pkg::CNT_W'(pidsl_pkg::CREDITS))
  `PIDSL_ASSERT(a_queue_within_credits, fifo_cnt_r <= inflight_r)
  `PIDSL_ASSERT_NEXT(a_credit_take, in_fire && !out_fire, inflight_r == $past(inflight_r) + 1'b1)
  `PIDSL_ASSERT_NEXT(a_credit_return, out_fire && !in_fire, inflight_r == $past(inflight_r) - 1'b1)

endmodule
